// ===== rtl/bmns_pkg.sv =====
// shared constants, types and bit-search functions of the bitmap scanner
`default_nettype none
package bmns_pkg;

  localparam int BITMAP_WORDS = 64;
  localparam int WordW        = 64;
  localparam int BitW         = 6;
  localparam int CursorW      = 13;
  localparam int WordNumW     = CursorW - BitW;
  localparam int WordIdxW     = 6;
  localparam int WordAddrW    = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int SpanCap      = BITMAP_WORDS * WordW;
  localparam int BaseW        = 32;
  localparam int PosW         = 33;
  localparam int OpW          = 3;
  localparam int PaddrW       = 3;
  localparam int PdataW       = 32;

  localparam logic [OpW-1:0] OP_WRITE     = 3'd0;
  localparam logic [OpW-1:0] OP_NEXT_ONE  = 3'd1;
  localparam logic [OpW-1:0] OP_NEXT_ZERO = 3'd2;
  localparam logic [OpW-1:0] OP_FIND_LAST = 3'd3;
  localparam logic [OpW-1:0] OP_REWIND    = 3'd4;

  localparam logic REG_SPAN_LENGTH = 1'b0;
  localparam logic REG_BASE_INDEX  = 1'b1;

  typedef struct packed {
    logic            nxt_hit;
    logic [BitW-1:0] nxt_bit;
    logic            one_hit;
    logic [BitW-1:0] one_bit;
    logic            zero_hit;
    logic [BitW-1:0] zero_bit;
  } word_res_t;

  // two-level search: pick the lowest nonzero byte, then the lowest bit in it
  function automatic logic [BitW-1:0] lowest_idx(input logic [WordW-1:0] v);
    logic [7:0] nz;
    logic [2:0] bsel;
    logic [2:0] isel;
    logic [7:0] byt;
    nz   = '0;
    bsel = '0;
    isel = '0;
    for (int j = 0; j < 8; j++) nz[j] = |v[8*j +: 8];
    for (int j = 7; j >= 0; j--) if (nz[j]) bsel = 3'(j);
    byt = v[8*bsel +: 8];
    for (int k = 7; k >= 0; k--) if (byt[k]) isel = 3'(k);
    return {bsel, isel};
  endfunction

  function automatic logic [BitW-1:0] highest_idx(input logic [WordW-1:0] v);
    logic [7:0] nz;
    logic [2:0] bsel;
    logic [2:0] isel;
    logic [7:0] byt;
    nz   = '0;
    bsel = '0;
    isel = '0;
    for (int j = 0; j < 8; j++) nz[j] = |v[8*j +: 8];
    for (int j = 0; j < 8; j++) if (nz[j]) bsel = 3'(j);
    byt = v[8*bsel +: 8];
    for (int k = 0; k < 8; k++) if (byt[k]) isel = 3'(k);
    return {bsel, isel};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bitmap_next_and_last_bit_scanner.sv =====
// top level: item sequencer, cursors, apb registers and result register
//
// Input beats (op, word_index, word_data) arrive on a valid/ready channel and
// each yields exactly one result beat on the output valid/ready channel.
// A write, rewind or unknown op, or a query that needs no word (cursor at the
// span end, empty span), goes straight to the result stage. A next-one /
// next-zero query walks the bitmap upward from its cursor word, one word per
// cycle through the registered read port of the word store; find-last walks
// downward from the span's top word until both a set and a clear bit are seen
// or word zero is reached. in_ready_o is high only while no item is in work,
// so the block does not take a new item before it is through with the last.
// A finished result sits in the output register until out_ready_i takes it;
// the next item may be accepted meanwhile, and its own result then waits in
// the sequencer, with in_ready_o low, until the output register frees up.
// Registers over apb: span_length at 0x0, base_index at 0x4; any write puts
// both cursors back to zero. pready is tied high.
// Reset (rst_ni low) clears cursors, sets span_length to 4096, base_index to
// zero and empties the output register; bitmap words are undefined until written.
`default_nettype none
module bitmap_next_and_last_bit_scanner
  import bmns_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [OpW-1:0]    op_i,
  input  wire logic [WordIdxW-1:0] word_index_i,
  input  wire logic [WordW-1:0]  word_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   one_found_o,
  output logic [PosW-1:0]        one_position_o,
  output logic                   zero_found_o,
  output logic [PosW-1:0]        zero_position_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0]      prdata,
  output logic                   pready
);

  localparam int IdxExtW = WordIdxW + WordAddrW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [OpW-1:0]      op_q;
  logic [CursorW-1:0]  cursor_one_q;
  logic [CursorW-1:0]  cursor_zero_q;
  logic [CursorW-1:0]  span_q;
  logic [BaseW-1:0]    base_q;
  logic [CursorW-1:0]  from_q;
  logic [WordNumW-1:0] rd_word_q;
  logic [WordNumW-1:0] ev_word_q;
  logic [WordNumW-1:0] last_word_q;
  logic                iss_q;
  logic                ev_vld_q;
  logic                res_one_found_q;
  logic [CursorW-1:0]  res_one_pos_q;
  logic                res_zero_found_q;
  logic [CursorW-1:0]  res_zero_pos_q;
  logic                out_valid_q;
  logic                out_one_found_q;
  logic [PosW-1:0]     out_one_pos_q;
  logic                out_zero_found_q;
  logic [PosW-1:0]     out_zero_pos_q;

  logic [CursorW-1:0]  len_eff;
  logic [CursorW-1:0]  len_m1;
  logic                in_acc;
  logic                cfg_wr;
  logic [IdxExtW-1:0]  wi_ext;
  logic                ram_wr;
  logic [WordW-1:0]    ram_rd_data;
  word_res_t           wres;
  logic [CursorW-1:0]  hit_pos;
  logic                fl_one;
  logic                fl_zero;

  assign len_eff = (int'(span_q) > SpanCap) ? CursorW'(SpanCap) : span_q;
  assign len_m1  = len_eff - CursorW'(1);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign cfg_wr     = psel && penable && pwrite;
  assign pready     = 1'b1;
  assign prdata     = paddr[2] ? base_q : PdataW'(span_q);

  assign wi_ext = IdxExtW'(word_index_i);
  assign ram_wr = in_acc && (op_i == OP_WRITE) && (wi_ext < IdxExtW'(BITMAP_WORDS));

  bmns_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr),
    .wr_addr_i (wi_ext[WordAddrW-1:0]),
    .wr_data_i (word_data_i),
    .rd_addr_i (WordAddrW'(rd_word_q)),
    .rd_data_o (ram_rd_data)
  );

  bmns_word u_word (
    .data_i     (ram_rd_data),
    .word_num_i (ev_word_q),
    .len_i      (len_eff),
    .from_i     (from_q),
    .from_en_i  (op_q != OP_FIND_LAST),
    .want_one_i (op_q == OP_NEXT_ONE),
    .res_o      (wres)
  );

  assign hit_pos = {ev_word_q, wres.nxt_bit};
  assign fl_one  = res_one_found_q || wres.one_hit;
  assign fl_zero = res_zero_found_q || wres.zero_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      op_q             <= OP_WRITE;
      cursor_one_q     <= '0;
      cursor_zero_q    <= '0;
      span_q           <= CursorW'(4096);
      base_q           <= '0;
      from_q           <= '0;
      rd_word_q        <= '0;
      ev_word_q        <= '0;
      last_word_q      <= '0;
      iss_q            <= 1'b0;
      ev_vld_q         <= 1'b0;
      res_one_found_q  <= 1'b0;
      res_one_pos_q    <= '0;
      res_zero_found_q <= 1'b0;
      res_zero_pos_q   <= '0;
      out_valid_q      <= 1'b0;
      out_one_found_q  <= 1'b0;
      out_one_pos_q    <= '0;
      out_zero_found_q <= 1'b0;
      out_zero_pos_q   <= '0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            op_q             <= op_i;
            res_one_found_q  <= 1'b0;
            res_one_pos_q    <= '0;
            res_zero_found_q <= 1'b0;
            res_zero_pos_q   <= '0;
            iss_q            <= 1'b1;
            ev_vld_q         <= 1'b0;
            last_word_q      <= len_m1[CursorW-1:BitW];
            state_q          <= ST_DONE;
            unique case (op_i)
              OP_NEXT_ONE: begin
                from_q    <= cursor_one_q;
                rd_word_q <= cursor_one_q[CursorW-1:BitW];
                if (cursor_one_q < len_eff) state_q <= ST_SCAN;
              end
              OP_NEXT_ZERO: begin
                from_q    <= cursor_zero_q;
                rd_word_q <= cursor_zero_q[CursorW-1:BitW];
                if (cursor_zero_q < len_eff) state_q <= ST_SCAN;
              end
              OP_FIND_LAST: begin
                rd_word_q <= len_m1[CursorW-1:BitW];
                if (len_eff != '0) state_q <= ST_SCAN;
              end
              OP_REWIND: begin
                cursor_one_q  <= '0;
                cursor_zero_q <= '0;
              end
              default: begin
              end
            endcase
          end
        end

        ST_SCAN: begin
          // read pipeline: issue one word address per cycle, evaluate it in the next cycle
          ev_vld_q  <= iss_q;
          ev_word_q <= rd_word_q;
          if (iss_q) begin
            if (op_q == OP_FIND_LAST) begin
              if (rd_word_q == '0) iss_q <= 1'b0;
              else rd_word_q <= rd_word_q - WordNumW'(1);
            end else begin
              if (rd_word_q == last_word_q) iss_q <= 1'b0;
              else rd_word_q <= rd_word_q + WordNumW'(1);
            end
          end
          if (ev_vld_q) begin
            if (op_q == OP_FIND_LAST) begin
              if (!res_one_found_q && wres.one_hit) begin
                res_one_found_q <= 1'b1;
                res_one_pos_q   <= {ev_word_q, wres.one_bit};
              end
              if (!res_zero_found_q && wres.zero_hit) begin
                res_zero_found_q <= 1'b1;
                res_zero_pos_q   <= {ev_word_q, wres.zero_bit};
              end
              if ((fl_one && fl_zero) || (ev_word_q == '0)) state_q <= ST_DONE;
            end else if (wres.nxt_hit) begin
              state_q <= ST_DONE;
              if (op_q == OP_NEXT_ONE) begin
                res_one_found_q <= 1'b1;
                res_one_pos_q   <= hit_pos;
                cursor_one_q    <= hit_pos + CursorW'(1);
              end else begin
                res_zero_found_q <= 1'b1;
                res_zero_pos_q   <= hit_pos;
                cursor_zero_q    <= hit_pos + CursorW'(1);
              end
            end else if (ev_word_q == last_word_q) begin
              // miss: park the cursor at the span end
              state_q <= ST_DONE;
              if (op_q == OP_NEXT_ONE) cursor_one_q <= len_eff;
              else cursor_zero_q <= len_eff;
            end
          end
        end

        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q      <= 1'b1;
            out_one_found_q  <= res_one_found_q;
            out_one_pos_q    <= res_one_found_q
                                ? ({1'b0, base_q} + PosW'(res_one_pos_q)) : '0;
            out_zero_found_q <= res_zero_found_q;
            out_zero_pos_q   <= res_zero_found_q
                                ? ({1'b0, base_q} + PosW'(res_zero_pos_q)) : '0;
            state_q          <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (cfg_wr) begin
        unique case (paddr[2])
          REG_SPAN_LENGTH: span_q <= pwdata[CursorW-1:0];
          REG_BASE_INDEX:  base_q <= pwdata[BaseW-1:0];
          default: begin
          end
        endcase
        cursor_one_q  <= '0;
        cursor_zero_q <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign one_found_o     = out_one_found_q;
  assign one_position_o  = out_one_pos_q;
  assign zero_found_o    = out_zero_found_q;
  assign zero_position_o = out_zero_pos_q;

endmodule
`default_nettype wire

// ===== rtl/bmns_ram.sv =====
// bitmap word store, one write port and one registered read port
`default_nettype none
module bmns_ram
  import bmns_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 wr_en_i,
  input  wire logic [WordAddrW-1:0] wr_addr_i,
  input  wire logic [WordW-1:0]     wr_data_i,
  input  wire logic [WordAddrW-1:0] rd_addr_i,
  output logic      [WordW-1:0]     rd_data_o
);

  logic [WordW-1:0] mem [BITMAP_WORDS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/bmns_word.sv =====
// per-word unit: span and cursor masking, lowest match and highest ones/zeros
`default_nettype none
module bmns_word
  import bmns_pkg::*;
(
  input  wire logic [WordW-1:0]    data_i,
  input  wire logic [WordNumW-1:0] word_num_i,
  input  wire logic [CursorW-1:0]  len_i,
  input  wire logic [CursorW-1:0]  from_i,
  input  wire logic                from_en_i,
  input  wire logic                want_one_i,
  output word_res_t                res_o
);

  logic [WordW-1:0] span_m;
  logic [WordW-1:0] from_m;
  logic [WordW-1:0] nxt_v;
  logic [WordW-1:0] ones_v;
  logic [WordW-1:0] zeros_v;
  logic [WordNumW-1:0] len_word;
  logic [BitW-1:0]     len_bit;

  assign len_word = len_i[CursorW-1:BitW];
  assign len_bit  = len_i[BitW-1:0];

  always_comb begin
    if (word_num_i < len_word) begin
      span_m = '1;
    end else if (word_num_i == len_word) begin
      span_m = (WordW'(1) << len_bit) - WordW'(1);
    end else begin
      span_m = '0;
    end
  end

  // the cursor word drops bits below the cursor when from_en_i is set
  assign from_m  = (from_en_i && (word_num_i == from_i[CursorW-1:BitW]))
                   ? ('1 << from_i[BitW-1:0]) : '1;
  assign nxt_v   = (want_one_i ? data_i : ~data_i) & span_m & from_m;
  assign ones_v  = data_i & span_m;
  assign zeros_v = ~data_i & span_m;

  always_comb begin
    res_o.nxt_hit  = |nxt_v;
    res_o.nxt_bit  = lowest_idx(nxt_v);
    res_o.one_hit  = |ones_v;
    res_o.one_bit  = highest_idx(ones_v);
    res_o.zero_hit = |zeros_v;
    res_o.zero_bit = highest_idx(zeros_v);
  end

endmodule
`default_nettype wire
